[src/alive_dead_id_set_core_assert.svh]
// Assertion macros shared by the alive/dead id set RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ALIVE_DEAD_ID_SET_CORE_ASSERT_SVH
`define ALIVE_DEAD_ID_SET_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ADSET_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ADSET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ADSET_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`define ADSET_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[src/adset_pkg.sv]
// Shared types and constants of the alive/dead id set block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package adset_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 1024;

  localparam int OP_W  = 3;
  localparam int ID_W  = 10;
  localparam int CFG_W = 11;
  localparam int RND_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_MAKE_ALIVE   = 3'd0,
    OP_MAKE_DEAD    = 3'd1,
    OP_SAMPLE_ALIVE = 3'd2,
    OP_SAMPLE_DEAD  = 3'd3,
    OP_APPEND       = 3'd4
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic use_input;    // lookups and decode come from the request port
    logic load_item;    // capture the request word
    logic load_cfg;     // start a rebuild from the configuration word
    logic rebuild;      // write one identity entry of the rebuild sweep
    logic swap;         // swap-with-last removal from the source list
    logic push;         // append an id at the end of a list
    logic push_fresh;   // the pushed id is the next new id, else the latched id
    logic push_alive;   // push into the alive list, else into the dead list
    logic mod_step;     // one bit of the remainder computation
    logic load_result;  // capture the response word
    logic res_changed;
    logic res_valid;
    logic res_err;
  } adset_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;   // latched operation code
    logic as_alive;        // latched append_as_alive
    logic id_over_cap;
    logic id_unknown;
    logic known_full;
    logic list_empty;
    logic cfg_zero;
    logic rebuild_last;
    logic extend_last;
    logic mod_last;
    logic rd_alive;        // membership bit read for the looked-up id
  } adset_status_t;

endpackage

[src/adset_ifs.sv]
// Valid/ready channel interfaces of the alive/dead id set block:
// request, response and configuration. Depends on adset_pkg.
interface adset_req_if import adset_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [ID_W-1:0]  id;
  logic             append_as_alive;
  logic [RND_W-1:0] random_value;

  modport source (output valid, operation, id, append_as_alive, random_value, input ready);
  modport sink   (input valid, operation, id, append_as_alive, random_value, output ready);
endinterface

interface adset_rsp_if import adset_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            changed;
  logic [ID_W-1:0] sampled_id;
  logic            sample_valid;
  logic            range_error;

  modport source (output valid, changed, sampled_id, sample_valid, range_error, input ready);
  modport sink   (input valid, changed, sampled_id, sample_valid, range_error, output ready);
endinterface

interface adset_cfg_if import adset_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] initial_alive;

  modport source (output valid, initial_alive, input ready);
  modport sink   (input valid, initial_alive, output ready);
endinterface

[src/adset_dp.sv]
// Datapath of the alive/dead id set: list, position and membership memories,
// counters, the bit-serial remainder unit and the response register. Uses adset_pkg.
module adset_dp import adset_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  adset_cmd_t       cmd,
  output adset_status_t    status,
  input  logic [OP_W-1:0]  req_operation,
  input  logic [ID_W-1:0]  req_id,
  input  logic             req_append_as_alive,
  input  logic [RND_W-1:0] req_random_value,
  input  logic [CFG_W-1:0] cfg_initial_alive,
  output logic             changed,
  output logic [ID_W-1:0]  sampled_id,
  output logic             sample_valid,
  output logic             range_error
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int BW = $clog2(RND_W);

  logic [IW-1:0] alive_list [CAPACITY];
  logic [IW-1:0] dead_list  [CAPACITY];
  logic [IW-1:0] pos_mem    [CAPACITY];
  logic          alive_bit  [CAPACITY];

  logic [IW-1:0] alive_rd, dead_rd, pos_rd;
  logic          bit_rd;

  logic [OP_W-1:0]  op_reg;
  logic [ID_W-1:0]  id_reg;
  logic             as_alive_reg;
  logic [RND_W-1:0] shreg;
  logic [CW-1:0]    rem;
  logic [BW-1:0]    bit_cnt;
  logic [CW-1:0]    alive_count, dead_count, known_count;
  logic [IW-1:0]    rb_idx;

  logic [OP_W-1:0] cur_op;
  logic [ID_W-1:0] cur_id;
  logic [IW-1:0]   lk_addr, list_raddr, last_addr, push_id;
  logic [CW-1:0]   src_count, last_idx, smp_count, dst_count, cfg_n;
  logic            sample_mode, src_alive;
  logic [CW:0]     trial;

  logic          al_we, dl_we, pos_we, bit_we;
  logic [IW-1:0] al_waddr, al_wdata, dl_waddr, dl_wdata, pos_waddr, pos_wdata, bit_waddr;
  logic          bit_wdata;

  always_comb begin
    cur_op      = cmd.use_input ? req_operation : op_reg;
    cur_id      = cmd.use_input ? req_id : id_reg;
    lk_addr     = IW'(cur_id);
    src_count   = (cur_op == OP_MAKE_DEAD) ? alive_count : dead_count;
    last_idx    = src_count - CW'(1);
    last_addr   = last_idx[IW-1:0];
    smp_count   = (cur_op == OP_SAMPLE_ALIVE) ? alive_count : dead_count;
    sample_mode = !cmd.use_input && (op_reg == OP_SAMPLE_ALIVE || op_reg == OP_SAMPLE_DEAD);
    list_raddr  = sample_mode ? rem[IW-1:0] : last_addr;
    src_alive   = (op_reg == OP_MAKE_DEAD);
    push_id     = cmd.push_fresh ? IW'(known_count) : IW'(id_reg);
    dst_count   = cmd.push_alive ? alive_count : dead_count;
    cfg_n       = (32'(cfg_initial_alive) > CAPACITY) ? CW'(CAPACITY) : CW'(cfg_initial_alive);
    trial       = {rem, shreg[RND_W-1]};
  end

  always_comb begin
    status.op           = op_reg;
    status.as_alive     = as_alive_reg;
    status.id_over_cap  = 32'(cur_id) >= CAPACITY;
    status.id_unknown   = 32'(cur_id) >= 32'(known_count);
    status.known_full   = known_count == CW'(CAPACITY);
    status.list_empty   = smp_count == '0;
    status.cfg_zero     = cfg_n == '0;
    status.rebuild_last = CW'(rb_idx) == known_count - CW'(1);
    status.extend_last  = 32'(known_count) == 32'(cur_id);
    status.mod_last     = bit_cnt == BW'(RND_W - 1);
    status.rd_alive     = bit_rd;
  end

  // Write ports of the four memories; at most one command writes per cycle.
  always_comb begin
    al_we = 1'b0;  al_waddr = '0;  al_wdata = '0;
    dl_we = 1'b0;  dl_waddr = '0;  dl_wdata = '0;
    pos_we = 1'b0; pos_waddr = '0; pos_wdata = '0;
    bit_we = 1'b0; bit_waddr = '0; bit_wdata = 1'b0;
    if (cmd.rebuild) begin
      al_we  = 1'b1; al_waddr  = rb_idx; al_wdata  = rb_idx;
      pos_we = 1'b1; pos_waddr = rb_idx; pos_wdata = rb_idx;
      bit_we = 1'b1; bit_waddr = rb_idx; bit_wdata = 1'b1;
    end else if (cmd.swap) begin
      // The last entry of the source list moves into the vacated slot.
      pos_we    = 1'b1;
      pos_wdata = pos_rd;
      if (src_alive) begin
        al_we = 1'b1; al_waddr = pos_rd; al_wdata = alive_rd; pos_waddr = alive_rd;
      end else begin
        dl_we = 1'b1; dl_waddr = pos_rd; dl_wdata = dead_rd; pos_waddr = dead_rd;
      end
    end else if (cmd.push) begin
      pos_we = 1'b1; pos_waddr = push_id; pos_wdata = IW'(dst_count);
      bit_we = 1'b1; bit_waddr = push_id; bit_wdata = cmd.push_alive;
      if (cmd.push_alive) begin
        al_we = 1'b1; al_waddr = IW'(alive_count); al_wdata = push_id;
      end else begin
        dl_we = 1'b1; dl_waddr = IW'(dead_count); dl_wdata = push_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (al_we) begin
      alive_list[al_waddr] <= al_wdata;
    end
    alive_rd <= alive_list[list_raddr];
  end

  always_ff @(posedge clk) begin
    if (dl_we) begin
      dead_list[dl_waddr] <= dl_wdata;
    end
    dead_rd <= dead_list[list_raddr];
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rd <= pos_mem[lk_addr];
  end

  always_ff @(posedge clk) begin
    if (bit_we) begin
      alive_bit[bit_waddr] <= bit_wdata;
    end
    bit_rd <= alive_bit[lk_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alive_count <= '0;
      dead_count  <= '0;
      known_count <= '0;
      rb_idx      <= '0;
      bit_cnt     <= '0;
    end else begin
      if (cmd.load_cfg) begin
        alive_count <= cfg_n;
        dead_count  <= '0;
        known_count <= cfg_n;
        rb_idx      <= '0;
      end else if (cmd.rebuild) begin
        rb_idx <= rb_idx + IW'(1);
      end else if (cmd.swap) begin
        if (src_alive) begin
          alive_count <= alive_count - CW'(1);
        end else begin
          dead_count <= dead_count - CW'(1);
        end
      end else if (cmd.push) begin
        if (cmd.push_alive) begin
          alive_count <= alive_count + CW'(1);
        end else begin
          dead_count <= dead_count + CW'(1);
        end
        if (cmd.push_fresh) begin
          known_count <= known_count + CW'(1);
        end
      end
      if (cmd.load_item) begin
        bit_cnt <= '0;
      end else if (cmd.mod_step) begin
        bit_cnt <= bit_cnt + BW'(1);
      end
    end
  end

  // Captures the request word; restoring remainder, one dividend bit per step, most significant first.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_reg       <= req_operation;
      id_reg       <= req_id;
      as_alive_reg <= req_append_as_alive;
      shreg        <= req_random_value;
      rem          <= '0;
    end else if (cmd.mod_step) begin
      shreg <= {shreg[RND_W-2:0], 1'b0};
      if (trial >= {1'b0, smp_count}) begin
        rem <= CW'(trial - {1'b0, smp_count});
      end else begin
        rem <= trial[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      changed      <= cmd.res_changed;
      sample_valid <= cmd.res_valid;
      range_error  <= cmd.res_err;
      if (cmd.res_valid) begin
        sampled_id <= ID_W'((op_reg == OP_SAMPLE_ALIVE) ? alive_rd : dead_rd);
      end else begin
        sampled_id <= '0;
      end
    end
  end

endmodule

[src/adset_ctrl.sv]
// Controller of the alive/dead id set: sequences rebuilds, moves, appends
// and samples and owns the handshakes. Uses adset_pkg and the assertion macros.
`include "alive_dead_id_set_core_assert.svh"

module adset_ctrl import adset_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output adset_cmd_t      cmd,
  input  adset_status_t   status
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_REBUILD = 10'b0000000010,
    S_EXTEND  = 10'b0000000100,
    S_LOOKUP  = 10'b0000001000,
    S_SWAP    = 10'b0000010000,
    S_PUSH    = 10'b0000100000,
    S_APPEND  = 10'b0001000000,
    S_MOD     = 10'b0010000000,
    S_SREAD   = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   res_changed, res_changed_next;
  logic   res_valid, res_valid_next;
  logic   res_err, res_err_next;
  logic   in_fire, cfg_fire, moving;

  always_comb begin
    cfg_ready = (state == S_IDLE);
    in_ready  = (state == S_IDLE) && !cfg_valid;
    cfg_fire  = cfg_valid && cfg_ready;
    in_fire   = in_valid && in_ready;
    moving    = (status.op == OP_MAKE_ALIVE) ? !status.rd_alive : status.rd_alive;

    cmd              = '0;
    cmd.use_input    = (state == S_IDLE);
    state_next       = state;
    res_changed_next = res_changed;
    res_valid_next   = res_valid;
    res_err_next     = res_err;

    case (state)
      S_IDLE: begin
        if (cfg_fire) begin
          cmd.load_cfg = 1'b1;
          if (!status.cfg_zero) begin
            state_next = S_REBUILD;
          end
        end else if (in_fire) begin
          cmd.load_item    = 1'b1;
          res_changed_next = 1'b0;
          res_valid_next   = 1'b0;
          res_err_next     = 1'b0;
          state_next       = S_DONE;
          case (in_op)
            OP_MAKE_ALIVE: begin
              if (status.id_over_cap) begin
                res_err_next = 1'b1;
              end else if (status.id_unknown) begin
                state_next = S_EXTEND;
              end else begin
                state_next = S_SWAP;
              end
            end
            OP_MAKE_DEAD: begin
              if (status.id_over_cap || status.id_unknown) begin
                res_err_next = 1'b1;
              end else begin
                state_next = S_SWAP;
              end
            end
            OP_SAMPLE_ALIVE, OP_SAMPLE_DEAD: begin
              if (!status.list_empty) begin
                res_valid_next = 1'b1;
                state_next     = S_MOD;
              end
            end
            OP_APPEND: begin
              if (status.known_full) begin
                res_err_next = 1'b1;
              end else begin
                state_next = S_APPEND;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_REBUILD: begin
        cmd.rebuild = 1'b1;
        if (status.rebuild_last) begin
          state_next = S_IDLE;
        end
      end
      S_EXTEND: begin
        // Missing ids join the dead list one per cycle, up to the target id.
        cmd.push       = 1'b1;
        cmd.push_fresh = 1'b1;
        if (status.extend_last) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: state_next = S_SWAP;
      S_SWAP: begin
        if (moving) begin
          cmd.swap   = 1'b1;
          state_next = S_PUSH;
        end else begin
          state_next = S_DONE;
        end
      end
      S_PUSH: begin
        cmd.push         = 1'b1;
        cmd.push_alive   = (status.op == OP_MAKE_ALIVE);
        res_changed_next = 1'b1;
        state_next       = S_DONE;
      end
      S_APPEND: begin
        cmd.push         = 1'b1;
        cmd.push_fresh   = 1'b1;
        cmd.push_alive   = status.as_alive;
        res_changed_next = 1'b1;
        state_next       = S_DONE;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) begin
          state_next = S_SREAD;
        end
      end
      S_SREAD: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    cmd.res_changed = res_changed;
    cmd.res_valid   = res_valid;
    cmd.res_err     = res_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      res_changed <= 1'b0;
      res_valid   <= 1'b0;
      res_err     <= 1'b0;
    end else begin
      state       <= state_next;
      res_changed <= res_changed_next;
      res_valid   <= res_valid_next;
      res_err     <= res_err_next;
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ADSET_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "request accepted while an item is in work")
  `ADSET_ASSERT_NEXT(a_cfg_starts_rebuild, clk, rst, cfg_valid && cfg_ready && !status.cfg_zero, state == S_REBUILD, "configuration write did not start a rebuild")
  `ADSET_ASSERT_IMPLIES(a_extend_make_alive, clk, rst, state == S_EXTEND, status.op == OP_MAKE_ALIVE, "list extension outside make_alive")
  `ADSET_ASSERT_IMPLIES(a_swap_move_op, clk, rst, state == S_SWAP, status.op == OP_MAKE_ALIVE || status.op == OP_MAKE_DEAD, "swap step outside a move")
  `ADSET_ASSERT_IMPLIES(a_result_flags, clk, rst, cmd.load_result, !(res_changed && res_err) && !(res_valid && (res_changed || res_err)), "inconsistent response flags")

endmodule

[src/alive_dead_id_set_core.sv]
// Top level of the alive/dead id set: a controller and a datapath joined by
// command and status structs. Depends on adset_pkg, adset_ifs, adset_ctrl and adset_dp.
//
// Usage. The request channel carries one word per operation: make_alive, make_dead,
// sample_alive, sample_dead or append_id. Each accepted request word yields exactly
// one response word (changed, sampled_id, sample_valid, range_error). The block works
// on one item at a time; request ready is high only while the controller is idle.
// A move looks up its id on accept, then passes the swap state and, if the id changes
// lists, the push state; a make_alive of an id at or beyond the known count first
// appends the missing ids as dead and looks up again. An append passes the append
// state; a rejected id, an unused code or an empty sample goes straight to the result
// state; a sample runs the bit-serial remainder unit, one bit of random_value per
// cycle, then reads the list. Moves share the position memory's single write port.
// The response sits in an output register, so a new request is taken while a finished
// response waits; a stalled receiver holds the next item in its final cycle.
// A configuration word starts a rebuild sweep of initial_alive identity entries (capped
// at CAPACITY), one per cycle, during which no request is taken.
// Reset empties both lists and clears the known count; the memories are not cleared.
module alive_dead_id_set_core import adset_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  adset_req_if.sink  request,
  adset_rsp_if.source response,
  adset_cfg_if.sink  cfg
);

  adset_cmd_t    cmd;
  adset_status_t status;

  // Sequencing of every operation and both handshakes.
  adset_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_op     (request.operation),
    .in_ready  (request.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .out_valid (response.valid),
    .out_ready (response.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Memories, counters, remainder unit and the response payload register.
  adset_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .req_operation       (request.operation),
    .req_id              (request.id),
    .req_append_as_alive (request.append_as_alive),
    .req_random_value    (request.random_value),
    .cfg_initial_alive   (cfg.initial_alive),
    .changed             (response.changed),
    .sampled_id          (response.sampled_id),
    .sample_valid        (response.sample_valid),
    .range_error         (response.range_error)
  );

endmodule
